FILE: rtl/core/cpp_pkg.sv
// Shared widths, register codes and pipeline payload types for the capsule point unit.
`default_nettype none
package cpp_pkg;

  localparam int CW = 32;
  localparam int NW = 2 * CW;
  localparam int SPACE_DIMS = 3;
  localparam int NLANE = 3;

  localparam logic [CW-2:0] LEN_RESET = '0;
  localparam logic [CW-2:0] RAD_RESET = (CW-1)'(65536);

  typedef enum logic [0:0] {
    REG_HALF_LENGTH = 1'b0,
    REG_CAP_RADIUS  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW:0]   cx;
    logic                 neg_x;
    logic                 neg_y;
    logic                 neg_z;
    logic                 cap;
    logic                 axis;
    logic                 ins;
    logic                 fully;
  } ride_t;

  typedef struct packed {
    ride_t                     ride;
    logic [NLANE-1:0][NW-1:0]  num;
  } sq_pay_t;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [CW-1:0] q;
    logic [CW-1:0] low;
  } dlane_t;

endpackage
`default_nettype wire

FILE: rtl/core/cpp_sqrt_cell.sv
// One root bit of the square root chain.
`default_nettype none
module cpp_sqrt_cell
  import cpp_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          up_v,
  input  wire logic [NW-1:0] up_rad,
  input  wire logic [CW-1:0] up_root,
  input  wire logic [CW+1:0] up_rem,
  input  wire sq_pay_t       up_pay,
  output logic               dn_v,
  output logic [NW-1:0]      dn_rad,
  output logic [CW-1:0]      dn_root,
  output logic [CW+1:0]      dn_rem,
  output sq_pay_t            dn_pay
);

  logic [CW+1:0] sh;
  logic [CW+1:0] trial;
  logic          ge;

  always_comb begin
    sh    = {up_rem[CW-1:0], up_rad[NW-1:NW-2]};
    trial = {up_root, 2'b01};
    ge    = sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_v <= 1'b0;
    end else if (en) begin
      dn_v <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_rad  <= {up_rad[NW-3:0], 2'b00};
      dn_root <= {up_root[CW-2:0], ge};
      dn_rem  <= ge ? (sh - trial) : sh;
      dn_pay  <= up_pay;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/cpp_div_cell.sv
// One quotient bit of the three-lane divide chain.
`default_nettype none
module cpp_div_cell
  import cpp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               up_v,
  input  wire logic [CW-1:0]      up_s,
  input  wire dlane_t [NLANE-1:0] up_lane,
  input  wire ride_t              up_ride,
  output logic                    dn_v,
  output logic [CW-1:0]           dn_s,
  output dlane_t [NLANE-1:0]      dn_lane,
  output ride_t                   dn_ride
);

  dlane_t [NLANE-1:0] nxt;
  logic   [CW:0]      sh;
  logic               ge;

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      sh = {up_lane[i].rem, up_lane[i].low[CW-1]};
      ge = sh >= {1'b0, up_s};
      nxt[i].rem = ge ? CW'(sh - {1'b0, up_s}) : sh[CW-1:0];
      nxt[i].q   = {up_lane[i].q[CW-2:0], ge};
      nxt[i].low = {up_lane[i].low[CW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_v <= 1'b0;
    end else if (en) begin
      dn_v <= up_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_s    <= up_s;
      dn_lane <= nxt;
      dn_ride <= up_ride;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/capsule_point_project_test.sv
// Top level: capsule inside test and surface projection pipeline.
`default_nettype none
// One point enters per cycle unless a result waits untaken. Registered
// stages form the magnitudes, the squares and products, and the sums, a row
// of 32 square root cells gives the distance one bit a cycle, a row of 32
// divide cells scales the three components one quotient bit a cycle, and a
// last stage forms the projection into the output register. The whole row
// advances together, so it stops while a result waits untaken. Configuration
// must be written only while no item is in flight.
module capsule_point_project_test
  import cpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [CW-2:0]        cfg_data,
  input  wire logic                 item_valid,
  output logic                      item_ready,
  input  wire logic signed [CW-1:0] x_coord,
  input  wire logic signed [CW-1:0] y_coord,
  input  wire logic signed [CW-1:0] z_coord,
  input  wire logic [CW-2:0]        margin,
  output logic                      result_valid,
  input  wire logic                 result_ready,
  output logic                      is_inside,
  output logic                      fully_inside,
  output logic signed [CW-1:0]      proj_x,
  output logic signed [CW-1:0]      proj_y,
  output logic signed [CW-1:0]      proj_z
);

  logic [CW-2:0] half_length;
  logic [CW-2:0] cap_radius;
  logic          en;

  assign en         = !result_valid || result_ready;
  assign item_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_length <= LEN_RESET;
      cap_radius  <= RAD_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_HALF_LENGTH) begin
        half_length <= cfg_data;
      end else begin
        cap_radius <= cfg_data;
      end
    end
  end

  // stage 1: magnitudes and branch
  logic [CW-1:0]    ax, ay, az, len_w, d_w, am;
  logic signed [CW:0] rm;
  logic             cap_w;
  logic signed [CW-1:0] z_in;
  ride_t            ride_w;

  always_comb begin
    z_in   = (SPACE_DIMS >= 3) ? z_coord : '0;
    ax     = x_coord[CW-1] ? (~x_coord + 1'b1) : x_coord;
    ay     = y_coord[CW-1] ? (~y_coord + 1'b1) : y_coord;
    az     = z_in[CW-1] ? (~z_in + 1'b1) : z_in;
    len_w  = {1'b0, half_length};
    cap_w  = ax > len_w;
    d_w    = cap_w ? (ax - len_w) : '0;
    rm     = $signed({2'b00, cap_radius}) - $signed({2'b00, margin});
    am     = rm[CW] ? CW'(-rm) : rm[CW-1:0];
    ride_w = '0;
    ride_w.x     = x_coord;
    ride_w.cx    = x_coord[CW-1] ? -$signed({1'b0, len_w}) : $signed({1'b0, len_w});
    ride_w.neg_x = x_coord[CW-1];
    ride_w.neg_y = y_coord[CW-1];
    ride_w.neg_z = z_in[CW-1];
    ride_w.cap   = cap_w;
  end

  logic          s1_v;
  logic [CW-1:0] s1_ay, s1_az, s1_d, s1_am;
  ride_t         s1_ride;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ay   <= ay;
      s1_az   <= az;
      s1_d    <= d_w;
      s1_am   <= am;
      s1_ride <= ride_w;
    end
  end

  // stage 2: squares and numerators
  logic          s2_v;
  logic [NW-1:0] s2_y2, s2_z2, s2_d2, s2_r2, s2_m2;
  logic [NLANE-1:0][NW-1:0] s2_num;
  ride_t         s2_ride;
  logic [CW-1:0] rad_w;

  assign rad_w = {1'b0, cap_radius};

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_y2     <= s1_ay * s1_ay;
      s2_z2     <= s1_az * s1_az;
      s2_d2     <= s1_d * s1_d;
      s2_r2     <= rad_w * rad_w;
      s2_m2     <= s1_am * s1_am;
      s2_num[0] <= rad_w * s1_d;
      s2_num[1] <= rad_w * s1_ay;
      s2_num[2] <= rad_w * s1_az;
      s2_ride   <= s1_ride;
    end
  end

  // stage 3: distance sums
  logic          s3_v;
  logic [NW-1:0] s3_n, s3_nyz, s3_r2, s3_m2;
  logic [NLANE-1:0][NW-1:0] s3_num;
  ride_t         s3_ride;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_nyz  <= s2_y2 + s2_z2;
      s3_n    <= s2_y2 + s2_z2 + s2_d2;
      s3_r2   <= s2_r2;
      s3_m2   <= s2_m2;
      s3_num  <= s2_num;
      s3_ride <= s2_ride;
    end
  end

  sq_pay_t       sq_in;
  logic [NW-1:0] rad_in;

  always_comb begin
    sq_in             = '0;
    sq_in.ride        = s3_ride;
    sq_in.ride.ins    = s3_n <= s3_r2;
    sq_in.ride.fully  = s3_n <= s3_m2;
    sq_in.ride.axis   = s3_nyz == '0;
    sq_in.num         = s3_num;
    rad_in            = s3_ride.cap ? s3_n : s3_nyz;
  end

  // square root row
  logic          sq_v    [0:CW];
  logic [NW-1:0] sq_rad  [0:CW];
  logic [CW-1:0] sq_root [0:CW];
  logic [CW+1:0] sq_rem  [0:CW];
  sq_pay_t       sq_pay  [0:CW];

  assign sq_v[0]    = s3_v;
  assign sq_rad[0]  = rad_in;
  assign sq_root[0] = '0;
  assign sq_rem[0]  = '0;
  assign sq_pay[0]  = sq_in;

  for (genvar i = 0; i < CW; i++) begin : g_sq
    cpp_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .up_v    (sq_v[i]),
      .up_rad  (sq_rad[i]),
      .up_root (sq_root[i]),
      .up_rem  (sq_rem[i]),
      .up_pay  (sq_pay[i]),
      .dn_v    (sq_v[i+1]),
      .dn_rad  (sq_rad[i+1]),
      .dn_root (sq_root[i+1]),
      .dn_rem  (sq_rem[i+1]),
      .dn_pay  (sq_pay[i+1])
    );
  end

  // divide row
  logic               dv_v    [0:CW];
  logic [CW-1:0]      dv_s    [0:CW];
  dlane_t [NLANE-1:0] dv_lane [0:CW];
  ride_t              dv_ride [0:CW];

  always_comb begin
    for (int i = 0; i < NLANE; i++) begin
      dv_lane[0][i].rem = sq_pay[CW].num[i][NW-1:CW];
      dv_lane[0][i].q   = '0;
      dv_lane[0][i].low = sq_pay[CW].num[i][CW-1:0];
    end
  end

  assign dv_v[0]    = sq_v[CW];
  assign dv_s[0]    = sq_root[CW];
  assign dv_ride[0] = sq_pay[CW].ride;

  for (genvar i = 0; i < CW; i++) begin : g_dv
    cpp_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .up_v    (dv_v[i]),
      .up_s    (dv_s[i]),
      .up_lane (dv_lane[i]),
      .up_ride (dv_ride[i]),
      .dn_v    (dv_v[i+1]),
      .dn_s    (dv_s[i+1]),
      .dn_lane (dv_lane[i+1]),
      .dn_ride (dv_ride[i+1])
    );
  end

  // final stage: signs, cap offset, saturation
  ride_t              fr;
  logic signed [CW:0]   sx, sy, sz;
  logic signed [CW+1:0] sum_x;
  logic signed [CW-1:0] px, py, pz;

  always_comb begin
    fr    = dv_ride[CW];
    sx    = fr.neg_x ? -$signed({1'b0, dv_lane[CW][0].q}) : $signed({1'b0, dv_lane[CW][0].q});
    sy    = fr.neg_y ? -$signed({1'b0, dv_lane[CW][1].q}) : $signed({1'b0, dv_lane[CW][1].q});
    sz    = fr.neg_z ? -$signed({1'b0, dv_lane[CW][2].q}) : $signed({1'b0, dv_lane[CW][2].q});
    sum_x = $signed({fr.cx[CW], fr.cx}) + $signed({sx[CW], sx});
    if (fr.cap) begin
      if (sum_x > $signed({3'b000, {(CW-1){1'b1}}})) begin
        px = {1'b0, {(CW-1){1'b1}}};
      end else if (sum_x < -$signed({3'b001, {(CW-1){1'b0}}})) begin
        px = {1'b1, {(CW-1){1'b0}}};
      end else begin
        px = sum_x[CW-1:0];
      end
      py = sy[CW-1:0];
      pz = sz[CW-1:0];
    end else begin
      px = fr.x;
      py = fr.axis ? $signed({1'b0, cap_radius}) : sy[CW-1:0];
      pz = fr.axis ? '0 : sz[CW-1:0];
    end
    if (SPACE_DIMS < 3) begin
      pz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= dv_v[CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      is_inside    <= fr.ins;
      fully_inside <= fr.fully;
      proj_x       <= px;
      proj_y       <= py;
      proj_z       <= pz;
    end
  end

`ifndef SYNTHESIS
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    sq_v[CW] |-> sq_rem[CW] <= {1'b0, sq_root[CW], 1'b0})
    else $error("square root remainder out of range");

  a_cap_root: assert property (@(posedge clk) disable iff (rst)
    (sq_v[CW] && sq_pay[CW].ride.cap) |-> sq_root[CW] != '0)
    else $error("zero distance beyond a cap");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[CW] && dv_s[CW] != '0 && !(dv_ride[CW].axis && !dv_ride[CW].cap))
      |-> (dv_lane[CW][0].rem < dv_s[CW] && dv_lane[CW][1].rem < dv_s[CW]
           && dv_lane[CW][2].rem < dv_s[CW]))
    else $error("divide remainder not below divisor");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv_v[CW]) && $stable(sq_v[CW]))
    else $error("pipeline moved during stall");
`endif

endmodule
`default_nettype wire

FILE: sim/cpp_checker.sv
// Checker for the capsule point unit: predicts each result and compares it.
`timescale 1ns / 100ps
module cpp_checker
  import cpp_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [0:0]           cfg_index,
  input  wire logic [CW-2:0]        cfg_data,
  input  wire logic                 item_valid,
  input  wire logic                 item_ready,
  input  wire logic signed [CW-1:0] x_coord,
  input  wire logic signed [CW-1:0] y_coord,
  input  wire logic signed [CW-1:0] z_coord,
  input  wire logic [CW-2:0]        margin,
  input  wire logic                 result_valid,
  input  wire logic                 result_ready,
  input  wire logic                 is_inside,
  input  wire logic                 fully_inside,
  input  wire logic signed [CW-1:0] proj_x,
  input  wire logic signed [CW-1:0] proj_y,
  input  wire logic signed [CW-1:0] proj_z,
  output int                        fail_count,
  output int                        pending
);

  typedef struct packed {
    logic                 ins;
    logic                 full;
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } proj_res_t;

  logic [CW-2:0] half_len;
  logic [CW-2:0] radius;
  proj_res_t     proj_q[$];

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic logic [127:0] sq(longint v);
    logic [127:0] m;
    m = {64'd0, mag(v)};
    return m * m;
  endfunction

  function automatic longint unsigned isqrt(logic [127:0] n);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= n) r = c;
    end
    return r[63:0];
  endfunction

  // trunc(r * c / s) with the sign of c
  function automatic longint scale(longint unsigned r, longint c, longint unsigned s);
    logic [127:0] num;
    logic [127:0] q;
    num = {64'd0, r} * {64'd0, mag(c)};
    q = (s == 0) ? '0 : num / {64'd0, s};
    return c < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic proj_res_t project(longint x, longint y, longint z, longint mg);
    proj_res_t    res;
    longint       len, rad, ax, d, cx, px, py, pz;
    logic [127:0] nyz, n;
    longint unsigned s;
    len = longint'(half_len);
    rad = longint'(radius);
    ax  = x < 0 ? -x : x;
    d   = ax > len ? ax - len : 0;
    nyz = sq(y) + sq(z);
    n   = nyz + sq(d);
    res.ins  = n <= sq(rad);
    res.full = n <= sq(rad - mg);
    if (ax > len) begin
      cx = x < 0 ? -len : len;
      s  = isqrt(n);
      px = cx + scale(rad, x - cx, s);
      if (px > 64'sd2147483647) px = 64'sd2147483647;
      if (px < -64'sd2147483648) px = -64'sd2147483648;
      py = scale(rad, y, s);
      pz = scale(rad, z, s);
    end else begin
      px = x;
      if (nyz != 0) begin
        s  = isqrt(nyz);
        py = scale(rad, y, s);
        pz = scale(rad, z, s);
      end else begin
        py = rad;
        pz = 0;
      end
    end
    if (SPACE_DIMS < 3) pz = 0;
    res.px = px[CW-1:0];
    res.py = py[CW-1:0];
    res.pz = pz[CW-1:0];
    return res;
  endfunction

  assign pending = proj_q.size();

  always @(posedge clk) begin
    proj_res_t want;
    proj_res_t got;
    if (rst) begin
      half_len <= LEN_RESET;
      radius   <= RAD_RESET;
      proj_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_HALF_LENGTH) half_len <= cfg_data;
        else if (cfg_index == REG_CAP_RADIUS) radius <= cfg_data;
      end
      if (item_valid && item_ready) begin
        proj_q.push_back(project(longint'(x_coord), longint'(y_coord),
                                 SPACE_DIMS >= 3 ? longint'(z_coord) : 0,
                                 longint'({1'b0, margin})));
      end
      if (result_valid && result_ready) begin
        got = '{is_inside, fully_inside, proj_x, proj_y, proj_z};
        if (proj_q.size() == 0) begin
          if (fail_count < 10) $display("checker: result with none pending");
          fail_count <= fail_count + 1;
        end else begin
          want = proj_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10)
              $display("checker: mismatch exp %0b %0b %0d %0d %0d got %0b %0b %0d %0d %0d",
                       want.ins, want.full, want.px, want.py, want.pz,
                       got.ins, got.full, got.px, got.py, got.pz);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

FILE: sim/tb.sv
// Testbench top: drives points and register writes into the capsule unit.
`timescale 1ns / 100ps
module tb;
  import cpp_pkg::*;

  localparam int LIMIT     = 2000000;
  localparam int LATENCY   = 80;
  localparam int N_PHASES  = 6;
  localparam int PER_PHASE = 190;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [0:0]           cfg_index = REG_HALF_LENGTH;
  logic [CW-2:0]        cfg_data = '0;
  logic                 item_valid = 1'b0;
  logic                 item_ready;
  logic signed [CW-1:0] x_coord = '0;
  logic signed [CW-1:0] y_coord = '0;
  logic signed [CW-1:0] z_coord = '0;
  logic [CW-2:0]        margin = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 is_inside, fully_inside;
  logic signed [CW-1:0] proj_x, proj_y, proj_z;
  int                   fail_count, pending;
  int                   cycles = 0;
  int                   send_idle = 16;
  int                   recv_idle = 81;
  logic [CW-2:0]        cur_len = '0;
  logic [CW-2:0]        cur_rad = 31'd65536;

  always #1 clk = ~clk;

  capsule_point_project_test u_top (.*);
  cpp_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_point(logic signed [CW-1:0] x, y, z, logic [CW-2:0] mg);
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk);
      item_valid <= 1'b0;
    end
    @(negedge clk);
    item_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    z_coord <= z;
    margin  <= mg;
    do @(posedge clk); while (!item_ready);
  endtask

  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CW-2:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [CW-1:0] pick_coord(longint span);
    case ($urandom_range(4))
      0: return $urandom;
      1: return CW'(longint'($urandom_range(32'(2 * span))) - span);
      2: return CW'(longint'($urandom_range(8 << 16)) - (4 << 16));
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return CW'(longint'($urandom_range(32'(2 * span))) - span);
    endcase
  endfunction

  task automatic directed();
    logic signed [CW-1:0] l, r;
    l = {1'b0, cur_len};
    r = {1'b0, cur_rad};
    send_point(0, 0, 0, 0);
    send_point(l, 0, 0, 0);
    send_point(-l, 0, 0, 31'h7fffffff);
    send_point(0, r, 0, 0);
    send_point(0, 0, -r, r[CW-2:0]);
    send_point(l + r, 0, 0, 0);
    send_point(-l - (2 << 16), 0, 0, 0);
    send_point(l + 1, 1, -1, 1);
    send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
    send_point(32'sh80000000, 32'sh80000000, 32'sh80000000, 0);
    send_point(32'sh80000000, 0, 0, 0);
    send_point(0, 32'sh80000000, 0, 0);
    send_point(0, 0, 32'sh7fffffff, 0);
    send_point(0, r >>> 1, r >>> 1, r[CW-2:0] + 31'd100);
    send_point(-1, -3 << 16, 5 << 16, 2 << 16);
  endtask

  initial begin
    logic [CW-2:0] lens[N_PHASES] = '{31'd0, 31'd196608, 31'h7fffffff, 31'd0,
                                      31'd6553600, 31'd65536};
    logic [CW-2:0] rads[N_PHASES] = '{31'd65536, 31'd98304, 31'h7fffffff, 31'd0,
                                      31'd1, 31'd300000};
    longint span;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed();
    drain();
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 2) begin
        send_idle = 81;
        recv_idle = 16;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      cur_len = lens[p];
      cur_rad = rads[p];
      write_reg(REG_HALF_LENGTH, cur_len);
      write_reg(REG_CAP_RADIUS, cur_rad);
      directed();
      span = longint'(cur_len) + 2 * longint'(cur_rad) + 2;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      for (int i = 0; i < PER_PHASE; i++)
        send_point(pick_coord(span), pick_coord(span), pick_coord(span),
                   $urandom_range(1) ? 31'($urandom) :
                                       31'($urandom_range(2 * cur_rad + 1)));
      drain();
    end
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
